FILE: sv/hftd_pkg.sv
`default_nettype none

package hftd_pkg;

  // alphabet and tree sizing
  localparam int unsigned SYMBOLS = 256;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned NODE_W  = SYM_W + 1;
  localparam int unsigned NODES   = SYMBOLS - 1;
  localparam int unsigned NODE_AW = 8;
  localparam int unsigned PAIR_W  = 2 * NODE_W;

  // image sizing
  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned COL_W   = 12;

  // code byte handling
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIT_CW  = 4;

  // commands
  localparam logic [1:0] CMD_MERGE  = 2'd0;
  localparam logic [1:0] CMD_DECODE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // control and status between top level and raster counter
  typedef struct packed {
    logic clear;
    logic step;
  } raster_ctrl_t;

  typedef struct packed {
    logic complete;
    logic done_next;
  } raster_stat_t;

  // control of the code bit shifter
  typedef struct packed {
    logic load;
    logic shift;
  } shift_ctrl_t;

  // clamp a dimension register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/hftd_ram.sv
`default_nettype none

module hftd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/hftd_shifter.sv
`default_nettype none

module hftd_shifter
  import hftd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire shift_ctrl_t       ctrl_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  output logic                   bit_o,
  output logic                   last_o
);

  logic [BYTE_W-1:0] sh_q, sh_d;
  logic [BIT_CW-1:0] cnt_q, cnt_d;

  // msb-first shift register with remaining bit count
  always_comb begin
    sh_d  = sh_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      sh_d  = byte_i;
      cnt_d = BIT_CW'(BYTE_W);
    end else if (ctrl_i.shift) begin
      sh_d  = {sh_q[BYTE_W-2:0], 1'b0};
      cnt_d = cnt_q - BIT_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign bit_o  = sh_q[BYTE_W-1];
  assign last_o = (cnt_q == BIT_CW'(1));

endmodule

`default_nettype wire

FILE: sv/hftd_raster.sv
`default_nettype none

module hftd_raster
  import hftd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire raster_ctrl_t     ctrl_i,
  input  wire logic [DIM_W-1:0] width_i,
  input  wire logic [DIM_W-1:0] height_i,
  output raster_stat_t          stat_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [DIM_W-1:0] width_c, height_c;
  logic [DIM_W-1:0] col_inc;
  logic             wrap;
  logic [DIM_W-1:0] row_next;

  assign width_c  = clamp_dim(width_i);
  assign height_c = clamp_dim(height_i);

  // position after one more pixel
  assign col_inc  = {1'b0, col_q} + DIM_W'(1);
  assign wrap     = (col_inc >= width_c);
  assign row_next = wrap ? (row_q + DIM_W'(1)) : row_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (ctrl_i.clear) begin
      col_d = '0;
      row_d = '0;
    end else if (ctrl_i.step) begin
      col_d = wrap ? '0 : col_inc[COL_W-1:0];
      row_d = row_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign stat_o.complete  = (row_q >= height_c);
  assign stat_o.done_next = (row_next >= height_c);

endmodule

`default_nettype wire

FILE: sv/huffman_tree_bit_decoder_unit.sv
// channel   | handshake                 | payload
// ----------+---------------------------+--------------------------------------------
// input     | in_valid_i / in_stall_o   | command_i, first_symbol_i, second_symbol_i,
//           |                           | code_byte_i
// output    | out_valid_o / out_stall_i | pixel_value_o, last_of_byte_o, image_done_o
// config    | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// a code byte is accepted, then decoded one code bit at a time (the node store read
// loop, one tree step per cycle while the output is not stalled), and finally the held
// last pixel is handed over. a merge makes two map reads and two map writes on one
// port; a clear completes in the idle state. reset is asynchronous, active low,
// and needs no clearing pass. a stalled output holds the walk at the next leaf.
`default_nettype none

module huffman_tree_bit_decoder_unit
  import hftd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        command_i,
  input  wire logic [SYM_W-1:0]  first_symbol_i,
  input  wire logic [SYM_W-1:0]  second_symbol_i,
  input  wire logic [BYTE_W-1:0] code_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [SYM_W-1:0]  pixel_value_o,
  output logic                   last_of_byte_o,
  output logic                   image_done_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [DIM_W-1:0]  cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MRG_A = 3'd1;
  localparam logic [2:0] ST_MRG_B = 3'd2;
  localparam logic [2:0] ST_MRG_W = 3'd3;
  localparam logic [2:0] ST_DEC   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [DIM_W-1:0]   width_q, height_q;
  logic [NODE_AW-1:0] count_q, count_d;
  logic [NODE_W-1:0]  walk_q, walk_d;
  logic [SYMBOLS-1:0] valid_q, valid_d;
  logic               vld_q, vld_d;
  logic [SYM_W-1:0]   a_q, b_q;
  logic [NODE_W-1:0]  left_q;

  logic               pend_valid_q, pend_valid_d;
  logic [SYM_W-1:0]   pend_pix_q, pend_pix_d;
  logic               pend_done_q, pend_done_d;

  logic               out_valid_q, out_valid_d;
  logic [SYM_W-1:0]   out_pix_q;
  logic               out_last_q, out_done_q;
  logic               out_load, out_last_d;
  logic               out_free;

  logic               in_accept;
  logic [NODE_AW-1:0] root_idx;
  logic [NODE_W-1:0]  root_id, new_id;

  // map store signals
  logic               map_we, map_rd_en;
  logic [SYM_W-1:0]   map_wr_addr, map_rd_addr;
  logic [NODE_W-1:0]  map_rd_data, map_sub;

  // node store signals
  logic               node_we, node_rd_en;
  logic [NODE_AW-1:0] node_rd_addr;
  logic [PAIR_W-1:0]  node_rd_data;
  logic [NODE_W-1:0]  child;
  logic               leaf, go;

  shift_ctrl_t        sh_ctrl;
  logic               code_bit, code_last;
  raster_ctrl_t       ras_ctrl;
  raster_stat_t       ras_stat;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign root_idx = count_q - NODE_AW'(1);
  assign root_id  = {1'b1, root_idx};
  assign new_id   = {1'b1, count_q};

  assign map_sub  = vld_q ? map_rd_data : {1'b0, (state_q == ST_MRG_A) ? a_q : b_q};
  assign child    = code_bit ? node_rd_data[NODE_W-1:0] : node_rd_data[PAIR_W-1:NODE_W];
  assign leaf     = !child[NODE_W-1];
  assign go       = !leaf || !pend_valid_q || out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    walk_d       = walk_q;
    valid_d      = valid_q;
    vld_d        = vld_q;
    pend_valid_d = pend_valid_q;
    pend_pix_d   = pend_pix_q;
    pend_done_d  = pend_done_q;
    out_load     = 1'b0;
    out_last_d   = 1'b0;
    map_we       = 1'b0;
    map_wr_addr  = b_q;
    map_rd_en    = 1'b0;
    map_rd_addr  = b_q;
    node_we      = 1'b0;
    node_rd_en   = 1'b0;
    node_rd_addr = child[NODE_AW-1:0];
    sh_ctrl      = '0;
    ras_ctrl     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (command_i)
            CMD_MERGE: begin
              if (count_q != NODE_AW'(NODES)) begin
                map_rd_en   = 1'b1;
                map_rd_addr = first_symbol_i;
                vld_d       = valid_q[first_symbol_i];
                state_d     = ST_MRG_A;
              end
            end
            CMD_DECODE: begin
              if ((count_q != '0) && !ras_stat.complete) begin
                node_rd_en = 1'b1;
                if (walk_q[NODE_W-1] && (walk_q[NODE_AW-1:0] <= root_idx)) begin
                  node_rd_addr = walk_q[NODE_AW-1:0];
                end else begin
                  node_rd_addr = root_idx;
                end
                sh_ctrl.load = 1'b1;
                state_d      = ST_DEC;
              end
            end
            CMD_CLEAR: begin
              valid_d        = '0;
              count_d        = '0;
              walk_d         = NODE_W'(SYMBOLS);
              ras_ctrl.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MRG_A: begin
        map_rd_en   = 1'b1;
        map_rd_addr = b_q;
        vld_d       = valid_q[b_q];
        state_d     = ST_MRG_B;
      end
      ST_MRG_B: begin
        node_we     = 1'b1;
        map_we      = 1'b1;
        map_wr_addr = a_q;
        valid_d[a_q] = 1'b1;
        state_d     = ST_MRG_W;
      end
      ST_MRG_W: begin
        map_we       = 1'b1;
        map_wr_addr  = b_q;
        valid_d[b_q] = 1'b1;
        count_d      = count_q + NODE_AW'(1);
        walk_d       = new_id;
        state_d      = ST_IDLE;
      end
      ST_DEC: begin
        if (ras_stat.complete) begin
          state_d = ST_FLUSH;
        end else if (go) begin
          node_rd_en    = 1'b1;
          sh_ctrl.shift = 1'b1;
          if (leaf) begin
            node_rd_addr  = root_idx;
            walk_d        = root_id;
            ras_ctrl.step = 1'b1;
            out_load      = pend_valid_q;
            pend_valid_d  = 1'b1;
            pend_pix_d    = child[SYM_W-1:0];
            pend_done_d   = ras_stat.done_next;
          end else begin
            walk_d = child;
          end
          if (code_last) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      walk_q       <= NODE_W'(SYMBOLS);
      valid_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      walk_q       <= walk_d;
      valid_q      <= valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // merge operands and held pixel
  always_ff @(posedge clk_i) begin
    vld_q       <= vld_d;
    pend_pix_q  <= pend_pix_d;
    pend_done_q <= pend_done_d;
    if ((state_q == ST_IDLE) && in_accept) begin
      a_q <= first_symbol_i;
      b_q <= second_symbol_i;
    end
    if (state_q == ST_MRG_A) begin
      left_q <= map_sub;
    end
  end

  // output register
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= pend_pix_q;
      out_last_q <= out_last_d;
      out_done_q <= pend_done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = out_pix_q;
  assign last_of_byte_o = out_last_q;
  assign image_done_o   = out_done_q;

  // symbol to subtree map
  hftd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (SYMBOLS)
  ) u_map_ram (
    .clk_i     (clk_i),
    .we_i      (map_we),
    .wr_addr_i (map_wr_addr),
    .wr_data_i (new_id),
    .rd_en_i   (map_rd_en),
    .rd_addr_i (map_rd_addr),
    .rd_data_o (map_rd_data)
  );

  // internal node store, left and right child ids
  hftd_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk_i     (clk_i),
    .we_i      (node_we),
    .wr_addr_i (count_q),
    .wr_data_i ({left_q, map_sub}),
    .rd_en_i   (node_rd_en),
    .rd_addr_i (node_rd_addr),
    .rd_data_o (node_rd_data)
  );

  hftd_shifter u_shifter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sh_ctrl),
    .byte_i (code_byte_i),
    .bit_o  (code_bit),
    .last_o (code_last)
  );

  hftd_raster u_raster (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ras_ctrl),
    .width_i  (width_q),
    .height_i (height_q),
    .stat_o   (ras_stat)
  );

endmodule

`default_nettype wire

FILE: sv/hftd_checker.sv
`default_nettype none

module hftd_checker
  import hftd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic [1:0]        command_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [SYM_W-1:0]  pixel_value_o,
  input wire logic              last_of_byte_o,
  input wire logic              image_done_o
);

  // a stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // a stalled payload does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(pixel_value_o) &&
      $stable(last_of_byte_o) && $stable(image_done_o)))
    else $error("output payload changed while stalled");

  // pixels only appear while an item is being worked on
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("pixel produced with no item in progress");

  // a clear never produces a pixel
  a_clear_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (command_i == CMD_CLEAR) && !out_valid_o)
      |=> !out_valid_o)
    else $error("clear produced a pixel");

endmodule

bind huffman_tree_bit_decoder_unit hftd_checker u_hftd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .command_i      (command_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pixel_value_o  (pixel_value_o),
  .last_of_byte_o (last_of_byte_o),
  .image_done_o   (image_done_o)
);

`default_nettype wire
